// ===== rtl/core/sfpb_pkg.sv =====
// ----------------------------------------------------------------------------
// sfpb_pkg: shared types and constants
// Register codes, write codes, sequencer states and the shared unit request.
// ----------------------------------------------------------------------------
package sfpb_pkg;

  localparam int unsigned PitchCap = 512;
  localparam int unsigned PitchW   = 10;
  localparam int unsigned UnitW    = 20;
  localparam int unsigned AddrW    = 15;
  localparam int unsigned ByteW    = 7;

  localparam logic [PitchW-1:0] RstRowPitch   = 10'd128;
  localparam logic [PitchW-1:0] RstUsedHeight = 10'd128;

  typedef enum logic [1:0] {
    CFG_ROW_PITCH   = 2'd0,
    CFG_BOX_LEFT    = 2'd1,
    CFG_BOX_BOTTOM  = 2'd2,
    CFG_USED_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_OR     = 2'd0,
    OP_AND    = 2'd1,
    OP_ASSIGN = 2'd2
  } write_op_e;

  typedef enum logic [1:0] {
    U_ADD,
    U_SUB,
    U_ADDNOT
  } unit_mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_FLIP,
    S_XSTART,
    S_XEND,
    S_CLIP,
    S_OR,
    S_AND,
    S_FULL,
    S_TAIL
  } seq_state_e;

  typedef struct packed {
    logic        [PitchW-1:0] row_pitch_bits;
    logic signed [15:0]       box_left;
    logic signed [15:0]       box_bottom;
    logic        [PitchW-1:0] used_height;
  } cfg_t;

  typedef struct packed {
    logic signed [UnitW-1:0] a;
    logic signed [UnitW-1:0] b;
    unit_mode_e              mode;
  } unit_req_t;

  function automatic logic signed [UnitW-1:0] sext16(input logic [15:0] v);
    return $signed({{(UnitW-16){v[15]}}, v});
  endfunction

  function automatic logic signed [UnitW-1:0] zext16(input logic [15:0] v);
    return $signed({{(UnitW-16){1'b0}}, v});
  endfunction

endpackage

// ===== rtl/core/sfpb_span_if.sv =====
// ----------------------------------------------------------------------------
// sfpb_span_if: span item channel
// Valid/ready channel carrying one antialiased span per item.
// ----------------------------------------------------------------------------
interface sfpb_span_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] span_row;
  logic signed [15:0] span_start;
  logic        [15:0] span_length;
  logic        [7:0]  span_coverage;
  logic               last_span;

  modport source (
    output valid, span_row, span_start, span_length, span_coverage, last_span,
    input  ready
  );

  modport sink (
    input  valid, span_row, span_start, span_length, span_coverage, last_span,
    output ready
  );
endinterface

// ===== rtl/core/sfpb_write_if.sv =====
// ----------------------------------------------------------------------------
// sfpb_write_if: byte write channel
// Valid/ready channel carrying one byte write command per item.
// ----------------------------------------------------------------------------
interface sfpb_write_if;
  logic        valid;
  logic        ready;
  logic [14:0] byte_address;
  logic [7:0]  byte_value;
  logic [1:0]  write_op;
  logic        span_inked;
  logic        last_write;

  modport source (
    output valid, byte_address, byte_value, write_op, span_inked, last_write,
    input  ready
  );

  modport sink (
    input  valid, byte_address, byte_value, write_op, span_inked, last_write,
    output ready
  );
endinterface

// ===== rtl/core/sfpb_cfg.sv =====
// ----------------------------------------------------------------------------
// sfpb_cfg: configuration registers
// Holds pitch, box edges and used height; written through a plain write port.
// ----------------------------------------------------------------------------
module sfpb_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  output sfpb_pkg::cfg_t     cfg_o
);
  import sfpb_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_pitch_bits <= RstRowPitch;
      cfg_q.box_left       <= '0;
      cfg_q.box_bottom     <= '0;
      cfg_q.used_height    <= RstUsedHeight;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ROW_PITCH:   cfg_q.row_pitch_bits <= cfg_data_i[PitchW-1:0];
        CFG_BOX_LEFT:    cfg_q.box_left       <= $signed(cfg_data_i);
        CFG_BOX_BOTTOM:  cfg_q.box_bottom     <= $signed(cfg_data_i);
        CFG_USED_HEIGHT: cfg_q.used_height    <= cfg_data_i[PitchW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/sfpb_unit.sv =====
// ----------------------------------------------------------------------------
// sfpb_unit: shared adder
// One signed adder used for the row flip, x offsets and byte addresses.
// ----------------------------------------------------------------------------
module sfpb_unit (
  input  sfpb_pkg::unit_req_t              req_i,
  output logic signed [sfpb_pkg::UnitW-1:0] sum_o
);
  import sfpb_pkg::*;

  logic signed [UnitW-1:0] b_op;
  logic                    cin;

  always_comb begin
    case (req_i.mode)
      U_ADD: begin
        b_op = req_i.b;
        cin  = 1'b0;
      end
      U_SUB: begin
        b_op = ~req_i.b;
        cin  = 1'b1;
      end
      U_ADDNOT: begin
        b_op = ~req_i.b;
        cin  = 1'b0;
      end
      default: begin
        b_op = req_i.b;
        cin  = 1'b0;
      end
    endcase
  end

  assign sum_o = req_i.a + b_op + $signed({{(UnitW-1){1'b0}}, cin});

endmodule

// ===== rtl/core/sfpb_seq.sv =====
// ----------------------------------------------------------------------------
// sfpb_seq: span sequencer
// Steps one span through flip and offset on the shared adder, clips it, then
// issues byte writes into an output register, one per cycle when it is free.
// ----------------------------------------------------------------------------
module sfpb_seq #(
  parameter int unsigned CAP_BITS = 512
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sfpb_pkg::cfg_t                     cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [15:0]                 span_row_i,
  input  logic signed [15:0]                 span_start_i,
  input  logic [15:0]                        span_length_i,
  input  logic [7:0]                         span_coverage_i,
  output sfpb_pkg::unit_req_t                unit_req_o,
  input  logic signed [sfpb_pkg::UnitW-1:0]  unit_sum_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sfpb_pkg::AddrW-1:0]         byte_address_o,
  output logic [7:0]                         byte_value_o,
  output logic [1:0]                         write_op_o,
  output logic                               last_write_o
);
  import sfpb_pkg::*;

  localparam logic [PitchW-1:0] CapLim = PitchW'(CAP_BITS < PitchCap ? CAP_BITS : PitchCap);

  seq_state_e state_q, state_d;

  logic signed [15:0]      row_q, start_q;
  logic [15:0]             len_q;
  logic signed [UnitW-1:0] t_q, y0_q, x0_q, xe_q;
  logic [PitchW-1:0]       x0c_q, xec_q;
  logic [AddrW-1:0]        rowbase_q;
  logic [ByteW-1:0]        bx_q;

  logic              out_valid_q;
  logic [AddrW-1:0]  addr_q;
  logic [7:0]        val_q;
  write_op_e         op_q;
  logic              last_q;

  logic [PitchW-1:0]       pitch_lim, w;
  logic signed [UnitW-1:0] w_s;
  logic                    y0_bad, x0_neg, drop;
  logic signed [UnitW-1:0] x0_cl, xe_cl;
  logic                    or_en, and_en, nfull_nz, tail_en, full_end;
  logic [ByteW-1:0]        xa_byte, xe_byte, bx_inc;
  logic [PitchW-1:0]       sh;
  logic [7:0]              or_mask, and_mask, tail_mask;
  logic                    slot_free, accept, emit, emit_last;
  logic [7:0]              emit_val;
  write_op_e               emit_op;

  assign pitch_lim = (cfg_i.row_pitch_bits > CapLim) ? CapLim : cfg_i.row_pitch_bits;
  assign w         = {pitch_lim[PitchW-1:3], 3'b000};
  assign w_s       = $signed({{(UnitW-PitchW){1'b0}}, w});

  assign y0_bad = (y0_q < 0) || (y0_q >= w_s);
  assign x0_neg = x0_q < 0;
  assign x0_cl  = x0_neg ? '0 : x0_q;
  assign xe_cl  = (xe_q > w_s) ? w_s : xe_q;
  assign drop   = (x0_neg && (xe_q <= 0)) || (x0_cl >= w_s);

  assign or_en    = x0c_q[2:0] != 3'b000;
  assign xa_byte  = x0c_q[PitchW-1:3] + ByteW'(or_en);
  assign xe_byte  = xec_q[PitchW-1:3];
  assign and_en   = !({xa_byte, 3'b000} < xec_q);
  assign nfull_nz = xe_byte != xa_byte;
  assign tail_en  = xec_q[2:0] != 3'b000;
  assign bx_inc   = bx_q + ByteW'(1);
  assign full_end = bx_inc == xe_byte;

  assign sh        = xec_q - {x0c_q[PitchW-1:3], 3'b000};
  assign or_mask   = 8'hFF << x0c_q[2:0];
  assign and_mask  = sh[3] ? 8'hFF : ((8'd1 << sh[2:0]) - 8'd1);
  assign tail_mask = (8'd1 << xec_q[2:0]) - 8'd1;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && span_coverage_i[7]) state_d = S_DIFF;
      end
      S_DIFF:   state_d = S_FLIP;
      S_FLIP:   state_d = S_XSTART;
      S_XSTART: state_d = y0_bad ? S_IDLE : S_XEND;
      S_XEND:   state_d = S_CLIP;
      S_CLIP:   state_d = drop ? S_IDLE : S_OR;
      S_OR: begin
        if (!or_en || slot_free) begin
          if (and_en)        state_d = S_AND;
          else if (nfull_nz) state_d = S_FULL;
          else               state_d = S_TAIL;
        end
      end
      S_AND: begin
        if (slot_free) state_d = S_IDLE;
      end
      S_FULL: begin
        if (slot_free && full_end) state_d = tail_en ? S_TAIL : S_IDLE;
      end
      S_TAIL: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    unit_req_o.a    = '0;
    unit_req_o.b    = '0;
    unit_req_o.mode = U_ADD;
    emit            = 1'b0;
    emit_val        = '0;
    emit_op         = OP_OR;
    emit_last       = 1'b0;
    case (state_q)
      S_DIFF: begin
        unit_req_o.a    = sext16(row_q);
        unit_req_o.b    = sext16(cfg_i.box_bottom);
        unit_req_o.mode = U_SUB;
      end
      S_FLIP: begin
        unit_req_o.a    = zext16({6'b0, cfg_i.used_height});
        unit_req_o.b    = t_q;
        unit_req_o.mode = U_ADDNOT;
      end
      S_XSTART: begin
        unit_req_o.a    = sext16(start_q);
        unit_req_o.b    = sext16(cfg_i.box_left);
        unit_req_o.mode = U_SUB;
      end
      S_XEND: begin
        unit_req_o.a = x0_q;
        unit_req_o.b = zext16(len_q);
      end
      S_OR: begin
        unit_req_o.a = zext16({1'b0, rowbase_q});
        unit_req_o.b = zext16({9'b0, x0c_q[PitchW-1:3]});
        emit         = or_en && slot_free;
        emit_val     = or_mask;
        emit_op      = OP_OR;
        emit_last    = !and_en && !nfull_nz && !tail_en;
      end
      S_AND: begin
        unit_req_o.a = zext16({1'b0, rowbase_q});
        unit_req_o.b = zext16({9'b0, x0c_q[PitchW-1:3]});
        emit         = slot_free;
        emit_val     = and_mask;
        emit_op      = OP_AND;
        emit_last    = 1'b1;
      end
      S_FULL: begin
        unit_req_o.a = zext16({1'b0, rowbase_q});
        unit_req_o.b = zext16({9'b0, bx_q});
        emit         = slot_free;
        emit_val     = 8'hFF;
        emit_op      = OP_ASSIGN;
        emit_last    = full_end && !tail_en;
      end
      S_TAIL: begin
        unit_req_o.a = zext16({1'b0, rowbase_q});
        unit_req_o.b = zext16({9'b0, xe_byte});
        emit         = slot_free;
        emit_val     = tail_mask;
        emit_op      = OP_ASSIGN;
        emit_last    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q   <= span_row_i;
      start_q <= span_start_i;
      len_q   <= span_length_i;
    end
    case (state_q)
      S_DIFF:   t_q  <= unit_sum_i;
      S_FLIP:   y0_q <= unit_sum_i;
      S_XSTART: x0_q <= unit_sum_i;
      S_XEND:   xe_q <= unit_sum_i;
      S_CLIP: begin
        x0c_q     <= x0_cl[PitchW-1:0];
        xec_q     <= xe_cl[PitchW-1:0];
        rowbase_q <= {6'b0, y0_q[8:0]} * {8'b0, w[PitchW-1:3]};
      end
      S_OR:     bx_q <= xa_byte;
      S_FULL: begin
        if (slot_free) bx_q <= bx_inc;
      end
      default: ;
    endcase
    if (emit) begin
      addr_q <= unit_sum_i[AddrW-1:0];
      val_q  <= emit_val;
      op_q   <= emit_op;
      last_q <= emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_address_o = addr_q;
  assign byte_value_o   = val_q;
  assign write_op_o     = op_q;
  assign last_write_o   = last_q;

endmodule

// ===== rtl/core/span_fill_packed_bitmap_top.sv =====
// An inked span steps through the diff, flip, x start, x end and clip states; its first write
//   comes from OR, or the state after it if the start is aligned. Up to 64 byte writes, held by
//   sink stalls, end before a new span is taken; coverage 127 or less or clipping gives none.
// Reset: asynchronous, active low; clears the sequencer and output valid, and
//   returns the registers to pitch 128, box edges 0, used height 128.
// ----------------------------------------------------------------------------
// span_fill_packed_bitmap_top: span to packed bitmap byte writer
// Turns antialiased spans into OR, AND and assign byte writes for a 1 bpp
// LSB-first bitmap, one write per cycle while the sink does not stall.
// ----------------------------------------------------------------------------
module span_fill_packed_bitmap_top #(
  parameter int unsigned MAX_ROW_BITS = 512
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sfpb_span_if.sink     span_i,
  sfpb_write_if.source  wr_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i
);
  import sfpb_pkg::*;

  cfg_t                    cfg;
  unit_req_t               unit_req;
  logic signed [UnitW-1:0] unit_sum;

  sfpb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sfpb_unit u_unit (
    .req_i (unit_req),
    .sum_o (unit_sum)
  );

  sfpb_seq #(
    .CAP_BITS (MAX_ROW_BITS)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (span_i.valid),
    .in_ready_o      (span_i.ready),
    .span_row_i      (span_i.span_row),
    .span_start_i    (span_i.span_start),
    .span_length_i   (span_i.span_length),
    .span_coverage_i (span_i.span_coverage),
    .unit_req_o      (unit_req),
    .unit_sum_i      (unit_sum),
    .out_valid_o     (wr_o.valid),
    .out_ready_i     (wr_o.ready),
    .byte_address_o  (wr_o.byte_address),
    .byte_value_o    (wr_o.byte_value),
    .write_op_o      (wr_o.write_op),
    .last_write_o    (wr_o.last_write)
  );

  assign wr_o.span_inked = 1'b1;

endmodule

// ===== rtl/core/sfpb_checker.sv =====
// ----------------------------------------------------------------------------
// sfpb_checker: port checks
// Watches the span and write channels of the top level over time.
// ----------------------------------------------------------------------------
module sfpb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [7:0]  in_coverage_i,
  input logic        wr_valid_i,
  input logic        wr_ready_i,
  input logic [14:0] wr_address_i,
  input logic [7:0]  wr_value_i,
  input logic [1:0]  wr_op_i,
  input logic        wr_inked_i,
  input logic        wr_last_i
);
  import sfpb_pkg::*;

  a_wr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_i && !wr_ready_i |=> wr_valid_i && $stable(wr_address_i) && $stable(wr_value_i)
      && $stable(wr_op_i) && $stable(wr_last_i))
    else $error("write item changed while stalled");

  a_inked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_i |-> wr_inked_i)
    else $error("write item without ink mark");

  a_and_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_i && (wr_op_i == OP_AND) |-> wr_last_i)
    else $error("AND write is not the last of its span");

  a_or_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_i && (wr_op_i == OP_OR) |-> !wr_last_i && (wr_value_i != 8'h00))
    else $error("OR write is last or has an empty mask");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_coverage_i[7] |=> !in_ready_i)
    else $error("ready after taking an inked span");

endmodule

bind span_fill_packed_bitmap_top sfpb_checker u_sfpb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (span_i.valid),
  .in_ready_i    (span_i.ready),
  .in_coverage_i (span_i.span_coverage),
  .wr_valid_i    (wr_o.valid),
  .wr_ready_i    (wr_o.ready),
  .wr_address_i  (wr_o.byte_address),
  .wr_value_i    (wr_o.byte_value),
  .wr_op_i       (wr_o.write_op),
  .wr_inked_i    (wr_o.span_inked),
  .wr_last_i     (wr_o.last_write)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: span to packed bitmap byte writer
// Feeds directed and random spans over several register settings and idle
// patterns, predicts the OR, AND and assign byte writes of each span, and
// checks every write field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  import sfpb_pkg::*;

  localparam int unsigned MaxRowBits   = 512;
  localparam int          HalfPeriod   = 6;
  localparam int          CycleLimit   = 1000000;
  localparam int          SettleCycles = 16;

  typedef struct packed {
    logic signed [15:0] row;
    logic signed [15:0] start;
    logic        [15:0] length;
    logic        [7:0]  coverage;
    logic               last;
  } span_t;

  typedef struct packed {
    logic [14:0] addr;
    logic [7:0]  value;
    write_op_e   op;
    logic        inked;
    logic        last;
  } byte_write_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;

  sfpb_span_if  span_bus ();
  sfpb_write_if wr_bus ();

  span_fill_packed_bitmap_top #(
    .MAX_ROW_BITS(MaxRowBits)
  ) uut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .span_i    (span_bus),
    .wr_o      (wr_bus),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  logic        [9:0]  pitch_reg;
  logic signed [15:0] left_reg;
  logic signed [15:0] bottom_reg;
  logic        [9:0]  height_reg;

  span_t       pending_spans[$];
  byte_write_t expected_writes[$];
  int          src_idle_pct;
  int          sink_stall_pct;
  int          mismatches;
  int          cycle_cnt;

  always #(HalfPeriod) clk = ~clk;

  function automatic int eff_pitch();
    int w;
    w = int'(pitch_reg);
    if (w > int'(MaxRowBits)) w = int'(MaxRowBits);
    if (w > int'(PitchCap)) w = int'(PitchCap);
    return w & ~7;
  endfunction

  function automatic byte_write_t make_write(int rowbase, int x, logic [7:0] value,
                                             write_op_e op);
    byte_write_t wr;
    wr.addr  = 15'(rowbase + (x >> 3));
    wr.value = value;
    wr.op    = op;
    wr.inked = 1'b1;
    wr.last  = 1'b0;
    return wr;
  endfunction

  function automatic void add_span(span_t s);
    pending_spans = {pending_spans, s};
  endfunction

  function automatic void predict_writes(span_t s);
    byte_write_t span_wr[$];
    byte_write_t wr;
    int          w, y0, x0, xe, xa, x, rowbase;
    logic [7:0]  mask;
    if (s.coverage <= 8'd127) return;
    w = eff_pitch();
    if (w <= 0) return;
    y0 = int'(height_reg) - 1 - (int'(s.row) - int'(bottom_reg));
    if (y0 < 0 || y0 >= w) return;
    x0 = int'(s.start) - int'(left_reg);
    xe = x0 + int'(s.length);
    if (x0 < 0) begin
      if (xe <= 0) return;
      x0 = 0;
    end
    if (x0 >= w) return;
    if (xe > w) xe = w;
    rowbase = y0 * (w >> 3);
    xa = (x0 + 7) & ~7;
    x = x0;
    mask = 8'(~(32'hFF >> (xa - x)));
    if (mask != 8'h00) span_wr = {span_wr, make_write(rowbase, x, mask, OP_OR)};
    if (xa < xe) begin
      x = xa;
    end else begin
      span_wr = {span_wr, make_write(rowbase, x, 8'((1 << (xe - (x & ~7))) - 1), OP_AND)};
      x = xe;
    end
    while (x < (xe & ~7)) begin
      span_wr = {span_wr, make_write(rowbase, x, 8'hFF, OP_ASSIGN)};
      x += 8;
    end
    if (x < xe) begin
      span_wr = {span_wr, make_write(rowbase, x, 8'((1 << (xe - x)) - 1), OP_ASSIGN)};
    end
    foreach (span_wr[i]) begin
      wr = span_wr[i];
      wr.last = (i == span_wr.size() - 1);
      expected_writes = {expected_writes, wr};
    end
  endfunction

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic span_t span_of(int row, int start, int len, int cov, bit last);
    span_t s;
    s.row      = 16'(row);
    s.start    = 16'(start);
    s.length   = 16'(len);
    s.coverage = 8'(cov);
    s.last     = last;
    return s;
  endfunction

  // mostly spans that land in the bitmap, some just outside, some pure noise
  function automatic span_t random_span();
    span_t s;
    int    w, y, x, len, kind;
    w = eff_pitch();
    if (w < 8) w = 8;
    kind = $urandom_range(99);
    y = $urandom_range(w - 1);
    x = $urandom_range(w - 1);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: len = $urandom_range(24);
      5, 6:          len = $urandom_range(72);
      7:             len = $urandom_range(w + 16);
      8:             len = $urandom_range(7);
      default:       len = $urandom_range(65535);
    endcase
    if (kind < 4) y = -1 - int'($urandom_range(3));
    else if (kind < 8) y = w + int'($urandom_range(3));
    if (kind >= 8 && kind < 18) x = -1 - int'($urandom_range(23));
    s.row      = clamp16(int'(height_reg) - 1 - y + int'(bottom_reg));
    s.start    = clamp16(x + int'(left_reg));
    s.length   = 16'(len);
    s.coverage = (kind % 7 == 0) ? 8'($urandom_range(127)) : 8'($urandom_range(255, 128));
    s.last     = 1'($urandom);
    if (kind >= 85) begin
      s.row      = 16'($urandom);
      s.start    = 16'($urandom);
      s.length   = 16'($urandom);
      s.coverage = 8'($urandom);
      s.last     = 1'($urandom);
    end
    return s;
  endfunction

  always @(posedge clk) begin : span_driver
    span_t taken;
    span_t nxt;
    if (span_bus.valid && span_bus.ready) begin
      taken.row      = span_bus.span_row;
      taken.start    = span_bus.span_start;
      taken.length   = span_bus.span_length;
      taken.coverage = span_bus.span_coverage;
      taken.last     = span_bus.last_span;
      predict_writes(taken);
    end
    if (!rst_n) begin
      span_bus.valid <= 1'b0;
    end else if (!span_bus.valid || span_bus.ready) begin
      if (pending_spans.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = pending_spans.pop_front();
        span_bus.valid         <= 1'b1;
        span_bus.span_row      <= nxt.row;
        span_bus.span_start    <= nxt.start;
        span_bus.span_length   <= nxt.length;
        span_bus.span_coverage <= nxt.coverage;
        span_bus.last_span     <= nxt.last;
      end else begin
        span_bus.valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : write_monitor
    byte_write_t want;
    if (wr_bus.valid && wr_bus.ready) begin
      if (expected_writes.size() == 0) begin
        $display("%0t: write with none expected, addr %0h value %0h op %0d", $time,
                 wr_bus.byte_address, wr_bus.byte_value, wr_bus.write_op);
        mismatches++;
      end else begin
        want = expected_writes.pop_front();
        check_field("byte_address", want.addr, wr_bus.byte_address);
        check_field("byte_value", want.value, wr_bus.byte_value);
        check_field("write_op", want.op, wr_bus.write_op);
        check_field("span_inked", want.inked, wr_bus.span_inked);
        check_field("last_write", want.last, wr_bus.last_write);
      end
    end
    wr_bus.ready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("[span_fill_packed_bitmap_top] ERROR");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_ROW_PITCH:   pitch_reg  = data[9:0];
      CFG_BOX_LEFT:    left_reg   = data;
      CFG_BOX_BOTTOM:  bottom_reg = data;
      CFG_USED_HEIGHT: height_reg = data[9:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [15:0] pitch, logic [15:0] left, logic [15:0] bottom,
                           logic [15:0] height);
    write_reg(CFG_ROW_PITCH, pitch);
    write_reg(CFG_BOX_LEFT, left);
    write_reg(CFG_BOX_BOTTOM, bottom);
    write_reg(CFG_USED_HEIGHT, height);
  endtask

  task automatic set_idling(int src_pct, int sink_pct);
    @(posedge clk);
    src_idle_pct   <= src_pct;
    sink_stall_pct <= sink_pct;
  endtask

  task automatic queue_random(int count);
    @(negedge clk);
    repeat (count) add_span(random_span());
  endtask

  // hold until every item is taken and every write has come, then let the block settle
  task automatic drain();
    do @(negedge clk);
    while (pending_spans.size() != 0 || span_bus.valid || expected_writes.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    clk                    = 1'b0;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = CFG_ROW_PITCH;
    cfg_data               = '0;
    span_bus.valid         = 1'b0;
    span_bus.span_row      = '0;
    span_bus.span_start    = '0;
    span_bus.span_length   = '0;
    span_bus.span_coverage = '0;
    span_bus.last_span     = 1'b0;
    wr_bus.ready           = 1'b0;
    src_idle_pct           = 0;
    sink_stall_pct         = 0;
    mismatches             = 0;
    cycle_cnt              = 0;
    pitch_reg              = RstRowPitch;
    left_reg               = '0;
    bottom_reg             = '0;
    height_reg             = RstUsedHeight;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    add_span(span_of(0, 0, 8, 127, 0));
    add_span(span_of(0, 0, 8, 0, 0));
    add_span(span_of(0, 0, 8, 128, 0));
    add_span(span_of(127, 3, 2, 255, 1));
    add_span(span_of(-32768, 0, 8, 200, 0));
    add_span(span_of(32767, 0, 8, 200, 0));
    add_span(span_of(128, 0, 8, 200, 0));
    add_span(span_of(10, -32768, 65535, 200, 0));
    add_span(span_of(10, 32767, 1, 200, 0));
    add_span(span_of(10, -5, 5, 200, 0));
    add_span(span_of(10, -5, 6, 200, 0));
    add_span(span_of(10, 8, 0, 200, 0));
    add_span(span_of(10, 3, 0, 200, 0));
    add_span(span_of(10, 3, 5, 200, 0));
    add_span(span_of(10, 5, 20, 200, 0));
    add_span(span_of(10, 0, 128, 255, 1));
    add_span(span_of(10, 127, 1, 200, 0));
    add_span(span_of(10, 128, 1, 200, 0));
    add_span(span_of(10, 100, 1000, 200, 0));
    add_span(span_of(10, 120, 8, 200, 1));
    add_span(span_of(-1, 64, 65535, 128, 0));
    add_span(span_of(0, 1, 127, 255, 1));
    drain();

    configure(16'd512, 16'd0, 16'h8000, 16'd512);
    queue_random(70);
    drain();

    configure(16'd8, 16'h8000, 16'h7FFF, 16'd0);
    set_idling(71, 0);
    queue_random(55);
    drain();

    configure(16'd1023, 16'h7FFF, 16'($urandom_range(40000) - 20000), 16'd1023);
    set_idling(0, 71);
    queue_random(70);
    drain();

    configure(16'd64, 16'd5, 16'hFFFD, 16'd40);
    set_idling(9, 9);
    queue_random(30);
    drain();
    queue_random(30);
    drain();

    configure(16'hFC00, 16'd0, 16'd0, 16'd128);
    set_idling(0, 0);
    queue_random(15);
    drain();
    write_reg(CFG_ROW_PITCH, 16'd7);
    queue_random(15);
    drain();

    configure(16'd256, 16'($urandom_range(60000) - 30000),
              16'($urandom_range(60000) - 30000), 16'd300);
    queue_random(70);
    drain();

    configure(16'd200, 16'($urandom_range(64) - 32), 16'($urandom_range(64) - 32), 16'd128);
    set_idling(9, 9);
    queue_random(70);
    drain();

    if (mismatches == 0) begin
      $display("[span_fill_packed_bitmap_top] OK");
    end else begin
      $display("[span_fill_packed_bitmap_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sfpb_pkg.sv
rtl/core/sfpb_span_if.sv
rtl/core/sfpb_write_if.sv
rtl/core/sfpb_cfg.sv
rtl/core/sfpb_unit.sv
rtl/core/sfpb_seq.sv
rtl/core/span_fill_packed_bitmap_top.sv
rtl/core/sfpb_checker.sv
tb/sv/testbench.sv
